// File: hw/rtl/rcp_pkg.sv
// ----------------------------------------------------------------------------
// rcp_pkg
// shared types, constants and the bytewise crc16 step of the chunk packetizer
// ----------------------------------------------------------------------------
package rcp_pkg;

    localparam int DATA_BYTES_DEF = 16;
    localparam int MAX_OUT        = 32;
    localparam int HDR_BYTES      = 6;
    localparam int CRC_BYTES      = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 9;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0]        MAGIC_RST      = 8'h69;
    localparam logic signed [8:0] STRONG_THR_RST = -9'sd90;
    localparam logic signed [8:0] WEAK_THR_RST   = -9'sd105;
    localparam logic [4:0]        STRONG_SZ_RST  = 5'd16;
    localparam logic [4:0]        MEDIUM_SZ_RST  = 5'd12;
    localparam logic [4:0]        WEAK_SZ_RST    = 5'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAGIC      = 3'd0,
        REG_STRONG_THR = 3'd1,
        REG_WEAK_THR   = 3'd2,
        REG_STRONG_SZ  = 3'd3,
        REG_MEDIUM_SZ  = 3'd4,
        REG_WEAK_SZ    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic init;
        logic upd;
    } t_crc_ctl;

    // msb-first crc16 over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/rcp_cfg.sv
// ----------------------------------------------------------------------------
// rcp_cfg
// configuration registers and rssi based chunk size selection
// ----------------------------------------------------------------------------
module rcp_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rcp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rcp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic signed [8:0]                  i_link_rssi,
    output logic [7:0]                         o_magic,
    output logic [4:0]                         o_chunk_raw
);

    logic [7:0]        r_magic;
    logic signed [8:0] r_strong_thr;
    logic signed [8:0] r_weak_thr;
    logic [4:0]        r_strong_sz;
    logic [4:0]        r_medium_sz;
    logic [4:0]        r_weak_sz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic      <= rcp_pkg::MAGIC_RST;
            r_strong_thr <= rcp_pkg::STRONG_THR_RST;
            r_weak_thr   <= rcp_pkg::WEAK_THR_RST;
            r_strong_sz  <= rcp_pkg::STRONG_SZ_RST;
            r_medium_sz  <= rcp_pkg::MEDIUM_SZ_RST;
            r_weak_sz    <= rcp_pkg::WEAK_SZ_RST;
        end else if (i_cfg_we) begin
            unique case (rcp_pkg::t_reg_idx'(i_cfg_idx))
                rcp_pkg::REG_MAGIC:      r_magic      <= i_cfg_data[7:0];
                rcp_pkg::REG_STRONG_THR: r_strong_thr <= $signed(i_cfg_data[8:0]);
                rcp_pkg::REG_WEAK_THR:   r_weak_thr   <= $signed(i_cfg_data[8:0]);
                rcp_pkg::REG_STRONG_SZ:  r_strong_sz  <= i_cfg_data[4:0];
                rcp_pkg::REG_MEDIUM_SZ:  r_medium_sz  <= i_cfg_data[4:0];
                rcp_pkg::REG_WEAK_SZ:    r_weak_sz    <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign o_magic = r_magic;

    always_comb begin
        if (i_link_rssi > r_strong_thr) begin
            o_chunk_raw = r_strong_sz;
        end else if (i_link_rssi > r_weak_thr) begin
            o_chunk_raw = r_medium_sz;
        end else begin
            o_chunk_raw = r_weak_sz;
        end
    end

endmodule

// File: hw/rtl/rcp_crc.sv
// ----------------------------------------------------------------------------
// rcp_crc
// running crc16 register, updated by one byte per cycle while upd is set
// ----------------------------------------------------------------------------
module rcp_crc (
    input  logic              i_clk,
    input  rcp_pkg::t_crc_ctl i_ctl,
    input  logic [7:0]        i_byte,
    output logic [15:0]       o_crc
);

    logic [15:0] r_crc;
    logic [15:0] w_base;

    assign w_base = i_ctl.init ? rcp_pkg::CRC_INIT : r_crc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd) begin
            r_crc <= rcp_pkg::crc_byte(w_base, i_byte);
        end
    end

    assign o_crc = r_crc;

endmodule

// File: hw/rtl/radio_chunk_packetizer_crc16.sv
// ----------------------------------------------------------------------------
// radio_chunk_packetizer_crc16
// splits one frame into packets of magic, descriptor, timestamp, chunk and crc16
// ----------------------------------------------------------------------------
// a frame of N = P*8 + DATA_BYTES output bytes in P packets keeps busy high until
// its last crc byte is formed; the first byte is strobed once the state register
// is in the header and the output register has taken the byte; one byte leaves
// per cycle through the shared bytewise crc unit; start is taken only when idle
// synchronous active-low reset restores the state, output and configuration registers and returns to idle
// the receiver cannot stall: each byte is on the ports for one cycle only
module radio_chunk_packetizer_crc16 #(
    parameter int DATA_BYTES = rcp_pkg::DATA_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [7:0]                     i_descriptor,
    input  logic [63:0]                    i_data_low,
    input  logic [63:0]                    i_data_high,
    input  logic signed [8:0]              i_link_rssi,
    input  logic [31:0]                    i_time_stamp,
    input  logic                           i_cfg_we,
    input  logic [rcp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rcp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_valid,
    output logic [7:0]                     o_out_byte,
    output logic                           o_packet_end,
    output logic                           o_frame_end
);

    localparam int MAX_PKTS  = (rcp_pkg::MAX_OUT - DATA_BYTES) /
                               (rcp_pkg::HDR_BYTES + rcp_pkg::CRC_BYTES);
    localparam int MIN_CHUNK = (DATA_BYTES + MAX_PKTS - 1) / MAX_PKTS;
    localparam int CW        = $clog2(DATA_BYTES + 1);
    localparam int DW        = DATA_BYTES * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_DATA,
        ST_CRC_LO,
        ST_CRC_HI
    } t_state;

    t_state            r_state, n_state;
    logic [2:0]        r_hidx, n_hidx;
    logic [CW-1:0]     r_rem, n_rem;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_chunk;
    logic [DW-1:0]     r_data;
    logic [7:0]        r_desc;
    logic [31:0]       r_ts;

    logic [7:0]        w_magic;
    logic [4:0]        w_chunk_raw;
    logic [4:0]        w_chunk_clamp;
    logic [127:0]      w_all;
    logic [7:0]        w_hdr_byte;
    logic [7:0]        w_byte;
    logic [15:0]       w_crc;
    logic              w_accept;
    logic [CW-1:0]     w_first_cnt;
    rcp_pkg::t_crc_ctl w_crc_ctl;

    rcp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_link_rssi (i_link_rssi),
        .o_magic     (w_magic),
        .o_chunk_raw (w_chunk_raw)
    );

    rcp_crc u_crc (
        .i_clk  (i_clk),
        .i_ctl  (w_crc_ctl),
        .i_byte (w_byte),
        .o_crc  (w_crc)
    );

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_all    = {i_data_high, i_data_low};

    always_comb begin
        if (w_chunk_raw < 5'(MIN_CHUNK)) begin
            w_chunk_clamp = 5'(MIN_CHUNK);
        end else if (w_chunk_raw > 5'(DATA_BYTES)) begin
            w_chunk_clamp = 5'(DATA_BYTES);
        end else begin
            w_chunk_clamp = w_chunk_raw;
        end
    end

    // header byte by position within the header
    always_comb begin
        case (r_hidx)
            3'd0:    w_hdr_byte = w_magic;
            3'd1:    w_hdr_byte = r_desc;
            3'd2:    w_hdr_byte = r_ts[7:0];
            3'd3:    w_hdr_byte = r_ts[15:8];
            3'd4:    w_hdr_byte = r_ts[23:16];
            default: w_hdr_byte = r_ts[31:24];
        endcase
    end

    always_comb begin
        case (r_state)
            ST_HDR:    w_byte = w_hdr_byte;
            ST_DATA:   w_byte = r_data[7:0];
            ST_CRC_LO: w_byte = w_crc[7:0];
            ST_CRC_HI: w_byte = w_crc[15:8];
            default:   w_byte = 8'h00;
        endcase
    end

    assign w_crc_ctl.init = (r_state == ST_HDR) && (r_hidx == 3'd0);
    assign w_crc_ctl.upd  = (r_state == ST_HDR) || (r_state == ST_DATA);

    // data bytes of the next packet
    assign w_first_cnt = (r_rem < r_chunk) ? r_rem : r_chunk;

    always_comb begin
        n_state = r_state;
        n_hidx  = r_hidx;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_HDR;
                    n_hidx  = 3'd0;
                    n_rem   = CW'(DATA_BYTES);
                end
            end
            ST_HDR: begin
                n_hidx = r_hidx + 3'd1;
                if (r_hidx == 3'(rcp_pkg::HDR_BYTES - 1)) begin
                    n_state = ST_DATA;
                    n_cnt   = w_first_cnt;
                end
            end
            ST_DATA: begin
                n_rem = r_rem - CW'(1);
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = ST_CRC_LO;
                end
            end
            ST_CRC_LO: begin
                n_state = ST_CRC_HI;
            end
            ST_CRC_HI: begin
                n_hidx  = 3'd0;
                n_state = (r_rem == '0) ? ST_IDLE : ST_HDR;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_hidx       <= 3'd0;
            r_rem        <= '0;
            r_cnt        <= '0;
            o_valid      <= 1'b0;
            o_out_byte   <= 8'h00;
            o_packet_end <= 1'b0;
            o_frame_end  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_hidx       <= n_hidx;
            r_rem        <= n_rem;
            r_cnt        <= n_cnt;
            o_valid      <= busy;
            o_out_byte   <= w_byte;
            o_packet_end <= (r_state == ST_CRC_HI);
            o_frame_end  <= (r_state == ST_CRC_HI) && (r_rem == '0);
        end
    end

    // frame payload, captured when start is taken and shifted out during the data phase
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data  <= w_all[DW-1:0];
            r_desc  <= i_descriptor;
            r_ts    <= i_time_stamp;
            r_chunk <= w_chunk_clamp[CW-1:0];
        end else if (r_state == ST_DATA) begin
            r_data <= r_data >> 8;
        end
    end

`ifndef SYNTHESIS
    a_frame_end_on_packet_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_end |-> o_packet_end)
        else $error("frame end without packet end");

    a_packet_end_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_packet_end |-> o_valid)
        else $error("packet end without strobe");

    a_strobe_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("byte strobed without a frame in progress");

    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start a frame");

    a_data_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DATA) |-> (r_cnt != '0) && (r_rem != '0))
        else $error("data phase with empty chunk count");
`endif

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the chunk packetizer: frames go in through the
// start/busy handshake, every strobed byte is compared against a local frame
// builder that tracks the register settings, over directed and random phases
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 5;
    localparam int N_DATA        = rcp_pkg::DATA_BYTES_DEF;
    localparam int HDR_BYTES     = rcp_pkg::HDR_BYTES;
    localparam int CRC_BYTES     = rcp_pkg::CRC_BYTES;
    localparam int CFG_IDX_W     = rcp_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W    = rcp_pkg::CFG_DATA_W;
    localparam int MAX_PKTS      = (rcp_pkg::MAX_OUT - N_DATA) / (HDR_BYTES + CRC_BYTES);
    localparam int MIN_CHUNK     = (N_DATA + MAX_PKTS - 1) / MAX_PKTS;
    localparam int LEN_ONE_PKT   = N_DATA + HDR_BYTES + CRC_BYTES;
    localparam int LEN_TWO_PKT   = N_DATA + 2 * (HDR_BYTES + CRC_BYTES);
    localparam int MAX_GAP       = 18;
    localparam int N_PHASES      = 6;
    localparam int PHASE_ITEMS   = 36;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 40;
    localparam int RUN_LIMIT     = 200000;
    localparam int RSSI_FLOOR    = -200;

    // indexes past the last register, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       pkt_end;
        logic       frm_end;
    } t_pkt_byte;

    typedef enum logic {ROW_FRAME, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        logic [7:0]            desc;
        logic [63:0]           dlo;
        logic [63:0]           dhi;
        logic signed [8:0]     rssi;
        logic [31:0]           ts;
        logic [5:0]            exp_len;
    } t_stim_row;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  start        = 1'b0;
    logic                  busy;
    logic [7:0]            i_descriptor = '0;
    logic [63:0]           i_data_low   = '0;
    logic [63:0]           i_data_high  = '0;
    logic signed [8:0]     i_link_rssi  = '0;
    logic [31:0]           i_time_stamp = '0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  o_valid;
    logic [7:0]            o_out_byte;
    logic                  o_packet_end;
    logic                  o_frame_end;

    // mirror of the register file
    logic [7:0]        cfg_magic      = rcp_pkg::MAGIC_RST;
    logic signed [8:0] cfg_strong_thr = rcp_pkg::STRONG_THR_RST;
    logic signed [8:0] cfg_weak_thr   = rcp_pkg::WEAK_THR_RST;
    logic [4:0]        cfg_strong_sz  = rcp_pkg::STRONG_SZ_RST;
    logic [4:0]        cfg_medium_sz  = rcp_pkg::MEDIUM_SZ_RST;
    logic [4:0]        cfg_weak_sz    = rcp_pkg::WEAK_SZ_RST;

    t_pkt_byte pending_bytes[$];
    t_stim_row stim_rows[$];
    int        fail_cnt  = 0;
    int        cycle_cnt = 0;

    radio_chunk_packetizer_crc16 u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_descriptor (i_descriptor),
        .i_data_low   (i_data_low),
        .i_data_high  (i_data_high),
        .i_link_rssi  (i_link_rssi),
        .i_time_stamp (i_time_stamp),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_out_byte   (o_out_byte),
        .o_packet_end (o_packet_end),
        .o_frame_end  (o_frame_end)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes outstanding",
                     cycle_cnt, pending_bytes.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        fail_cnt++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // bitwise crc16, feedback taken from the top bit xor the data bit
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? rcp_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // queue up every byte one frame must produce under the current registers
    task automatic frame_packets(input logic [7:0] desc, input logic [63:0] dlo,
                                 input logic [63:0] dhi, input logic signed [8:0] rssi,
                                 input logic [31:0] ts, output int n_bytes);
        logic [127:0] payload;
        logic [7:0]   hdr [HDR_BYTES];
        logic [15:0]  crc;
        int           chunk;
        int           pos;
        int           n;
        logic         last;
        payload = {dhi, dlo};
        if (rssi > cfg_strong_thr) begin
            chunk = int'(cfg_strong_sz);
        end else if (rssi > cfg_weak_thr) begin
            chunk = int'(cfg_medium_sz);
        end else begin
            chunk = int'(cfg_weak_sz);
        end
        if (chunk < MIN_CHUNK) chunk = MIN_CHUNK;
        if (chunk > N_DATA) chunk = N_DATA;
        hdr[0] = cfg_magic;
        hdr[1] = desc;
        for (int i = 0; i < 4; i++) hdr[2 + i] = ts[8*i +: 8];
        pos     = 0;
        n_bytes = 0;
        while (pos < N_DATA) begin
            n    = (N_DATA - pos > chunk) ? chunk : N_DATA - pos;
            last = (pos + n >= N_DATA);
            crc  = rcp_pkg::CRC_INIT;
            for (int i = 0; i < HDR_BYTES; i++) begin
                crc = crc16_step(crc, hdr[i]);
                pending_bytes.push_back({hdr[i], 1'b0, 1'b0});
            end
            for (int j = 0; j < n; j++) begin
                crc = crc16_step(crc, payload[8*(pos + j) +: 8]);
                pending_bytes.push_back({payload[8*(pos + j) +: 8], 1'b0, 1'b0});
            end
            pending_bytes.push_back({crc[7:0], 1'b0, 1'b0});
            pending_bytes.push_back({crc[15:8], 1'b1, last});
            n_bytes += n + HDR_BYTES + CRC_BYTES;
            pos     += n;
        end
    endtask

    // start stays high from one item to the next when there is no gap
    task automatic send_frame(input logic [7:0] desc, input logic [63:0] dlo,
                              input logic [63:0] dhi, input logic signed [8:0] rssi,
                              input logic [31:0] ts, input int gap, output int n_bytes);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_descriptor <= desc;
        i_data_low   <= dlo;
        i_data_high  <= dhi;
        i_link_rssi  <= rssi;
        i_time_stamp <= ts;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        frame_packets(desc, dlo, dhi, rssi, ts, n_bytes);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            rcp_pkg::REG_MAGIC:      cfg_magic      = val[7:0];
            rcp_pkg::REG_STRONG_THR: cfg_strong_thr = val;
            rcp_pkg::REG_WEAK_THR:   cfg_weak_thr   = val;
            rcp_pkg::REG_STRONG_SZ:  cfg_strong_sz  = val[4:0];
            rcp_pkg::REG_MEDIUM_SZ:  cfg_medium_sz  = val[4:0];
            rcp_pkg::REG_WEAK_SZ:    cfg_weak_sz    = val[4:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic add_frame(input logic [7:0] desc, input logic [63:0] dlo,
                             input logic [63:0] dhi, input int rssi,
                             input logic [31:0] ts, input int exp_len);
        t_stim_row r;
        r         = '0;
        r.kind    = ROW_FRAME;
        r.desc    = desc;
        r.dlo     = dlo;
        r.dhi     = dhi;
        r.rssi    = 9'(rssi);
        r.ts      = ts;
        r.exp_len = 6'(exp_len);
        stim_rows.push_back(r);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
        t_stim_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.val  = 9'(val);
        stim_rows.push_back(r);
    endtask

    always @(posedge i_clk) begin : byte_check
        t_pkt_byte want;
        if (i_rst_n && o_valid) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("byte %02h with nothing expected", o_out_byte));
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_byte !== want.data) begin
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              o_out_byte, want.data));
                end
                if (o_packet_end !== want.pkt_end) begin
                    report_mismatch($sformatf("packet_end %b, want %b",
                                              o_packet_end, want.pkt_end));
                end
                if (o_frame_end !== want.frm_end) begin
                    report_mismatch($sformatf("frame_end %b, want %b",
                                              o_frame_end, want.frm_end));
                end
            end
        end
    end

    initial begin
        t_stim_row         r;
        int                n_bytes;
        int                gap;
        int                v;
        bit                no_idle;
        logic [8:0]        wval;
        logic signed [8:0] rssi;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: strong above -90, medium above -105, weak otherwise
        add_frame(8'h00, 64'h0, 64'h0, 0, 32'h0, LEN_ONE_PKT);
        add_frame(8'hFF, '1, '1, -1, 32'hFFFF_FFFF, LEN_ONE_PKT);
        add_frame(8'h5A, 64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF, -89,
                  32'h1234_5678, LEN_ONE_PKT);
        add_frame(8'hA5, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, -90,
                  32'h8000_0001, LEN_TWO_PKT);
        add_frame(8'h3C, 64'hDEAD_BEEF_CAFE_F00D, 64'h0F0F_F0F0_55AA_AA55, -104,
                  32'h0000_FFFF, LEN_TWO_PKT);
        add_frame(8'hC3, 64'h1, 64'h8000_0000_0000_0000, -105, 32'hFFFF_0000, LEN_TWO_PKT);
        add_frame(8'h81, 64'h8000_0000_0000_0000, 64'h1, RSSI_FLOOR, 32'h7FFF_FFFF,
                  LEN_TWO_PKT);
        add_cfg(rcp_pkg::REG_MAGIC, 0);
        add_frame(8'h11, 64'h2222_3333_4444_5555, 64'h6666_7777_8888_9999, 0, 32'h1,
                  LEN_ONE_PKT);
        add_cfg(rcp_pkg::REG_MAGIC, 9'h1FF);
        add_frame(8'h22, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 0, 32'h2,
                  LEN_ONE_PKT);
        // chunk size below the floor is raised, one above it is kept
        add_cfg(rcp_pkg::REG_STRONG_SZ, 0);
        add_frame(8'h33, 64'hFFFF_0000_FFFF_0000, 64'h0000_FFFF_0000_FFFF, 0, 32'h3,
                  LEN_TWO_PKT);
        add_cfg(rcp_pkg::REG_STRONG_SZ, 1);
        add_frame(8'h44, 64'h0102_0304_0506_0708, 64'h090A_0B0C_0D0E_0F10, 0, 32'h4,
                  LEN_TWO_PKT);
        add_cfg(rcp_pkg::REG_STRONG_SZ, 9);
        add_frame(8'h55, 64'h1111_1111_1111_1111, 64'hEEEE_EEEE_EEEE_EEEE, 0, 32'h5,
                  LEN_TWO_PKT);
        // chunk size at or above the data length gives one packet, a zero weak size is raised
        add_cfg(rcp_pkg::REG_STRONG_SZ, 17);
        add_frame(8'h66, 64'h0, '1, 0, 32'h6, LEN_ONE_PKT);
        add_cfg(rcp_pkg::REG_STRONG_SZ, 9'h1FF);
        add_frame(8'h77, '1, 64'h0, 0, 32'h7, LEN_ONE_PKT);
        add_cfg(rcp_pkg::REG_MEDIUM_SZ, 16);
        add_frame(8'h88, 64'hCAFE_BABE_0000_0001, 64'h1234_0000_0000_4321, -100, 32'h8,
                  LEN_ONE_PKT);
        add_cfg(rcp_pkg::REG_WEAK_SZ, 0);
        add_frame(8'h99, 64'h7777_7777_7777_7777, 64'h8888_8888_8888_8888, RSSI_FLOOR,
                  32'h9, LEN_TWO_PKT);
        // threshold extremes, equal values fall to the next size down
        add_cfg(rcp_pkg::REG_STRONG_THR, 0);
        add_cfg(rcp_pkg::REG_WEAK_THR, RSSI_FLOOR);
        add_frame(8'hAA, 64'h0, 64'h0, 0, 32'hA, LEN_ONE_PKT);
        add_frame(8'hBB, '1, '1, RSSI_FLOOR + 1, 32'hB, LEN_ONE_PKT);
        add_frame(8'hCC, 64'h1, 64'h1, RSSI_FLOOR, 32'hC, LEN_TWO_PKT);
        // inverted pair: strong test still goes first
        add_cfg(rcp_pkg::REG_STRONG_THR, RSSI_FLOOR);
        add_cfg(rcp_pkg::REG_WEAK_THR, 0);
        add_frame(8'hDD, 64'h2, 64'h2, RSSI_FLOOR + 1, 32'hD, LEN_ONE_PKT);
        add_frame(8'hEE, 64'h3, 64'h3, RSSI_FLOOR, 32'hE, LEN_TWO_PKT);
        // writes past the register file change nothing
        add_cfg(REG_SPARE_LO, 0);
        add_cfg(REG_SPARE_HI, 9'h1FF);
        add_frame(8'hF0, 64'h4, 64'h4, RSSI_FLOOR, 32'hF, LEN_TWO_PKT);

        foreach (stim_rows[i]) begin
            r = stim_rows[i];
            if (r.kind == ROW_CFG) begin
                wait_idle();
                write_reg(r.idx, r.val);
            end else begin
                send_frame(r.desc, r.dlo, r.dhi, r.rssi, r.ts,
                           $urandom_range(0, MAX_GAP), n_bytes);
                if (r.exp_len != 0 && n_bytes != r.exp_len) begin
                    report_mismatch($sformatf("frame %0d length %0d, want %0d",
                                              i, n_bytes, r.exp_len));
                end
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            if (ph == 0) begin
                write_reg(rcp_pkg::REG_MAGIC, 9'h000);
                write_reg(rcp_pkg::REG_STRONG_THR, 9'd0);
                write_reg(rcp_pkg::REG_WEAK_THR, 9'(RSSI_FLOOR));
                write_reg(rcp_pkg::REG_STRONG_SZ, 9'd0);
                write_reg(rcp_pkg::REG_MEDIUM_SZ, 9'd1);
                write_reg(rcp_pkg::REG_WEAK_SZ, 9'd31);
            end else if (ph == N_PHASES - 1) begin
                write_reg(rcp_pkg::REG_MAGIC, 9'h0FF);
                write_reg(rcp_pkg::REG_STRONG_THR, 9'(RSSI_FLOOR));
                write_reg(rcp_pkg::REG_WEAK_THR, 9'd0);
                write_reg(rcp_pkg::REG_STRONG_SZ, 9'd16);
                write_reg(rcp_pkg::REG_MEDIUM_SZ, 9'd8);
                write_reg(rcp_pkg::REG_WEAK_SZ, 9'd16);
            end else begin
                write_reg(rcp_pkg::REG_MAGIC, 9'($urandom_range(0, 511)));
                for (int t = 0; t < 2; t++) begin
                    v    = -int'($urandom_range(0, -RSSI_FLOOR));
                    wval = 9'(v);
                    write_reg(t == 0 ? rcp_pkg::REG_STRONG_THR : rcp_pkg::REG_WEAK_THR, wval);
                end
                for (int t = 0; t < 3; t++) begin
                    // half the time a size that matters, with junk in the upper bits
                    if ($urandom_range(0, 1)) begin
                        wval = 9'($urandom_range(0, 511));
                    end else begin
                        wval = {4'($urandom_range(0, 15)), 5'($urandom_range(MIN_CHUNK, N_DATA))};
                    end
                    case (t)
                        0:       write_reg(rcp_pkg::REG_STRONG_SZ, wval);
                        1:       write_reg(rcp_pkg::REG_MEDIUM_SZ, wval);
                        default: write_reg(rcp_pkg::REG_WEAK_SZ, wval);
                    endcase
                end
                if ($urandom_range(0, 1)) begin
                    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                              9'($urandom_range(0, 511)));
                end
            end

            no_idle = (ph == 1) || ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                case ($urandom_range(0, 3))
                    0: v = -int'($urandom_range(0, -RSSI_FLOOR));
                    1: v = int'(cfg_strong_thr) + int'($urandom_range(0, 2)) - 1;
                    2: v = int'(cfg_weak_thr) + int'($urandom_range(0, 2)) - 1;
                    default: begin
                        case ($urandom_range(0, 2))
                            0:       v = 0;
                            1:       v = -1;
                            default: v = RSSI_FLOOR;
                        endcase
                    end
                endcase
                if (v > 0) v = 0;
                if (v < RSSI_FLOOR) v = RSSI_FLOOR;
                rssi = 9'(v);
                gap  = no_idle ? 0 : $urandom_range(0, MAX_GAP);
                send_frame(8'($urandom_range(0, 255)), {$urandom, $urandom},
                           {$urandom, $urandom}, rssi, $urandom, gap, n_bytes);
                // now and then let the block drain completely mid-phase
                if ($urandom_range(0, 30) == 0) wait_idle();
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_bytes.size() != 0) begin
            report_mismatch($sformatf("%0d expected bytes never came", pending_bytes.size()));
        end
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
